@@ design/htll_pkg.sv @@
// ----------------------------------------------------------------------------
// Hash tree level layout package
// Shared widths, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package htll_pkg;

  localparam int unsigned WordW      = 64;
  localparam int unsigned HashBlockW = 21;
  localparam int unsigned DigestW    = 11;
  localparam int unsigned BitsW      = 5;
  localparam int unsigned FanMax     = HashBlockW - 1;
  localparam int unsigned ShW        = 7;
  localparam int unsigned CountW     = 7;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned ShiftLimit = 64;
  localparam int unsigned ShiftMax   = ShiftLimit - 1;
  localparam int unsigned MaxLevelsDef = 63;

  localparam int unsigned InDataW  = 2 * WordW;
  localparam int unsigned OutDataW = 208;
  localparam int unsigned OutUserW = 4;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [HashBlockW-1:0] HashBlockRst = HashBlockW'(4096);
  localparam logic [DigestW-1:0]    DigestRst    = DigestW'(32);

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_GEOMETRY = 3'd1,
    ST_TOO_MANY     = 3'd2,
    ST_SHIFT_OVER   = 3'd3,
    ST_POS_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_GEOM,
    EMIT_MANY,
    EMIT_EMPTY,
    EMIT_SHIFT,
    EMIT_LEVEL
  } emit_e;

  typedef enum logic {
    REG_HASH_BLOCK = 1'b0,
    REG_DIGEST     = 1'b1
  } reg_e;

  typedef struct packed {
    logic [HashBlockW-1:0] hash_block_bytes;
    logic [DigestW-1:0]    digest_bytes;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  step;
    logic  prep;
    logic  calc;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    logic geom_bad;
    logic count_more;
    logic too_many;
    logic no_levels;
    logic sh_over;
    logic pos_ovf;
    logic idx_zero;
    logic out_free;
  } sts_t;

endpackage

@@ design/htll_regs.sv @@
// ----------------------------------------------------------------------------
// Hash tree level layout configuration registers
// APB-style register file holding the hash block size and digest size.
// ----------------------------------------------------------------------------
module htll_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [htll_pkg::ApbAddrW-1:0]       paddr,
  input  logic [htll_pkg::ApbDataW-1:0]       pwdata,
  output logic [htll_pkg::ApbDataW-1:0]       prdata,
  output logic                                pready,
  output htll_pkg::cfg_t                      cfg_o
);

  htll_pkg::cfg_t cfg_q, cfg_d;
  htll_pkg::reg_e sel;
  logic           wr_en;

  assign sel    = htll_pkg::reg_e'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        htll_pkg::REG_HASH_BLOCK: begin
          cfg_d.hash_block_bytes = pwdata[htll_pkg::HashBlockW-1:0];
        end
        htll_pkg::REG_DIGEST: begin
          cfg_d.digest_bytes = pwdata[htll_pkg::DigestW-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      htll_pkg::REG_HASH_BLOCK: prdata = htll_pkg::ApbDataW'(cfg_q.hash_block_bytes);
      htll_pkg::REG_DIGEST:     prdata = htll_pkg::ApbDataW'(cfg_q.digest_bytes);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hash_block_bytes <= htll_pkg::HashBlockRst;
      cfg_q.digest_bytes     <= htll_pkg::DigestRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/htll_ctrl.sv @@
// ----------------------------------------------------------------------------
// Hash tree level layout controller
// Sequences loading, level counting, per-level size computation and result
// emission.
// ----------------------------------------------------------------------------
module htll_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  htll_pkg::sts_t sts_i,
  output htll_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,
    S_CALC,
    S_CHECK
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    cmd_o.prep = 1'b0;
    cmd_o.calc = 1'b0;
    cmd_o.emit = htll_pkg::EMIT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_COUNT;
        end
      end
      S_COUNT: begin
        if (sts_i.geom_bad) begin
          if (sts_i.out_free) begin
            cmd_o.emit = htll_pkg::EMIT_GEOM;
            state_d    = S_IDLE;
          end
        end else if (sts_i.count_more) begin
          cmd_o.step = 1'b1;
        end else if (sts_i.too_many) begin
          if (sts_i.out_free) begin
            cmd_o.emit = htll_pkg::EMIT_MANY;
            state_d    = S_IDLE;
          end
        end else if (sts_i.no_levels) begin
          if (sts_i.out_free) begin
            cmd_o.emit = htll_pkg::EMIT_EMPTY;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.prep = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        if (sts_i.sh_over) begin
          if (sts_i.out_free) begin
            cmd_o.emit = htll_pkg::EMIT_SHIFT;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.calc = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.out_free) begin
          cmd_o.emit = htll_pkg::EMIT_LEVEL;
          state_d    = (sts_i.pos_ovf || sts_i.idx_zero) ? S_IDLE : S_CALC;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/htll_dp.sv @@
// ----------------------------------------------------------------------------
// Hash tree level layout datapath
// Holds the item operands, counts levels one fan-out shift per cycle,
// computes each level size and keeps the output result register.
// ----------------------------------------------------------------------------
module htll_dp #(
  parameter int unsigned MAX_LEVELS = htll_pkg::MaxLevelsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  htll_pkg::cfg_t                    cfg_i,
  input  logic [htll_pkg::InDataW-1:0]      in_data_i,
  input  htll_pkg::cmd_t                    cmd_i,
  output htll_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [htll_pkg::OutDataW-1:0]     out_data_o,
  output logic [htll_pkg::OutUserW-1:0]     out_user_o,
  output logic                              out_last_o
);

  localparam int unsigned W = htll_pkg::WordW;

  logic [W-1:0]                  blocks_q, pos_q, v_q, s_q;
  logic [htll_pkg::BitsW-1:0]    bits_q, bits_calc;
  logic                          geom_bad_q;
  logic [htll_pkg::ShW-1:0]      sh_q;
  logic [htll_pkg::CountW-1:0]   levels_q;
  logic [htll_pkg::IdxW-1:0]     idx_q;
  logic [W-1:0]                  mask;
  logic [W:0]                    pos_sum;

  logic                          out_valid_q;
  logic                          o_has_q, o_last_q;
  logic [htll_pkg::IdxW-1:0]     o_idx_q;
  logic [W-1:0]                  o_start_q, o_blocks_q, o_end_q;
  logic [htll_pkg::CountW-1:0]   o_count_q;
  htll_pkg::status_e             o_status_q;

  always_comb begin
    bits_calc = '0;
    for (int n = 1; n <= int'(htll_pkg::FanMax); n++) begin
      if ((32'(cfg_i.digest_bytes) << n) <= 32'(cfg_i.hash_block_bytes)) begin
        bits_calc = htll_pkg::BitsW'(n);
      end
    end
  end

  assign mask    = (W'(1) << sh_q[htll_pkg::IdxW-1:0]) - W'(1);
  assign pos_sum = {1'b0, pos_q} + {1'b0, s_q};

  assign sts_o.geom_bad   = geom_bad_q;
  assign sts_o.count_more = (sh_q < htll_pkg::ShW'(htll_pkg::ShiftLimit)) && (v_q != '0);
  assign sts_o.too_many   = levels_q > htll_pkg::CountW'(MAX_LEVELS);
  assign sts_o.no_levels  = (levels_q == '0);
  assign sts_o.sh_over    = sh_q > htll_pkg::ShW'(htll_pkg::ShiftMax);
  assign sts_o.pos_ovf    = pos_sum[W];
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      blocks_q   <= in_data_i[W-1:0];
      pos_q      <= in_data_i[2*W-1:W];
      v_q        <= in_data_i[W-1:0] - W'(1);
      sh_q       <= '0;
      levels_q   <= '0;
      bits_q     <= bits_calc;
      geom_bad_q <= (cfg_i.digest_bytes == '0) || (bits_calc == '0);
    end
    if (cmd_i.step) begin
      v_q      <= v_q >> bits_q;
      sh_q     <= sh_q + htll_pkg::ShW'(bits_q);
      levels_q <= levels_q + htll_pkg::CountW'(1);
    end
    if (cmd_i.prep) begin
      idx_q <= htll_pkg::IdxW'(levels_q - htll_pkg::CountW'(1));
    end
    if (cmd_i.calc) begin
      s_q <= (blocks_q + mask) >> sh_q[htll_pkg::IdxW-1:0];
    end
    if (cmd_i.emit == htll_pkg::EMIT_LEVEL && !pos_sum[W]) begin
      pos_q <= pos_sum[W-1:0];
      sh_q  <= sh_q - htll_pkg::ShW'(bits_q);
      idx_q <= idx_q - htll_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != htll_pkg::EMIT_NONE) begin
      o_start_q <= pos_q;
      o_end_q   <= pos_q;
      o_has_q   <= 1'b0;
      o_last_q  <= 1'b1;
      o_idx_q   <= '0;
      o_blocks_q <= '0;
      o_count_q <= levels_q;
      o_status_q <= htll_pkg::ST_OK;
      case (cmd_i.emit)
        htll_pkg::EMIT_GEOM: begin
          o_count_q  <= '0;
          o_status_q <= htll_pkg::ST_BAD_GEOMETRY;
        end
        htll_pkg::EMIT_MANY: begin
          o_status_q <= htll_pkg::ST_TOO_MANY;
        end
        htll_pkg::EMIT_SHIFT: begin
          o_idx_q    <= idx_q;
          o_status_q <= htll_pkg::ST_SHIFT_OVER;
        end
        htll_pkg::EMIT_LEVEL: begin
          o_idx_q    <= idx_q;
          o_blocks_q <= s_q;
          if (pos_sum[W]) begin
            o_status_q <= htll_pkg::ST_POS_OVERFLOW;
          end else begin
            o_has_q  <= 1'b1;
            o_end_q  <= pos_sum[W-1:0];
            o_last_q <= (idx_q == '0);
          end
        end
        default: begin
          o_status_q <= htll_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != htll_pkg::EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = o_last_q;
  assign out_user_o  = {o_status_q, o_has_q};
  assign out_data_o  = {3'b000, o_count_q, o_end_q, o_blocks_q, o_start_q, o_idx_q};

endmodule

@@ design/hash_tree_level_layout.sv @@
// ----------------------------------------------------------------------------
// Hash tree level layout
// Lays out the levels of a hash tree for a data block count and a start
// position, one result beat per level from the top level down to level 0.
//
// The slave stream takes one item per beat: data_blocks and start_position.
// The master stream returns the levels; tlast marks the final beat of an
// item, and an error ends the item with a beat that has a nonzero status.
// The APB port sets the hash block size and the digest size; the user
// must write them only while idle, which the block does not enforce.
// An item is loaded, its levels are counted by the fan-out shift loop
// (at most 64), then each level is sized, checked for overflow and emitted.
// One item is worked on at a time; the next item is accepted once the
// final beat sits in the output register, while it still waits.
// A stalled receiver holds the output beat and pauses the sequencer.
// Reset empties the output register, returns to idle and restores the
// register defaults of 4096 and 32 bytes.
// ----------------------------------------------------------------------------
module hash_tree_level_layout #(
  parameter int unsigned MAX_LEVELS = htll_pkg::MaxLevelsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // data_blocks [63:0], start_position [127:64]
  input  logic [htll_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // level_index [5:0], level_start [69:6], level_blocks [133:70],
  // end_position [197:134], level_count [204:198], zero [207:205]
  output logic [htll_pkg::OutDataW-1:0]     m_axis_tdata,
  // has_level [0], status [3:1]
  output logic [htll_pkg::OutUserW-1:0]     m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [htll_pkg::ApbAddrW-1:0]     paddr,
  input  logic [htll_pkg::ApbDataW-1:0]     pwdata,
  output logic [htll_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  htll_pkg::cfg_t cfg;
  htll_pkg::cmd_t cmd;
  htll_pkg::sts_t sts;

  htll_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  htll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  htll_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  a_level_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:1] == htll_pkg::ST_OK)
    else $error("level beat with nonzero status");

  a_mid_is_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0])
    else $error("non-final beat is not a level");

  a_last_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tuser[0] |-> m_axis_tdata[5:0] == '0)
    else $error("final level beat is not level 0");

  a_end_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[197:134] == m_axis_tdata[69:6] + m_axis_tdata[133:70])
    else $error("end position does not match start plus size");

endmodule
